>>> rtl/core/smwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smwa_pkg
// shared types and constants for the sign-magnitude wide alu
// ----------------------------------------------------------------------------
package smwa_pkg;

  localparam int OPERAND_BYTES = 8;
  localparam int MAG_W = OPERAND_BYTES * 8;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int BYTE_CNT_W = $clog2(OPERAND_BYTES + 1);

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4
  } mode_t;

  localparam logic [1:0] CMP_LESS    = 2'd0;
  localparam logic [1:0] CMP_EQUAL   = 2'd1;
  localparam logic [1:0] CMP_GREATER = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic iterative;
    logic last;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic             a_negative;
    logic [63:0]      a_magnitude;
    logic             b_negative;
    logic [63:0]      b_magnitude;
  } in_item_t;

  typedef struct packed {
    logic        result_negative;
    logic [63:0] result_magnitude;
    logic [1:0]  compare_result;
    logic [1:0]  error_code;
  } out_item_t;

  // byte count up to and including highest nonzero byte
  function automatic logic [BYTE_CNT_W-1:0] sig_bytes(input logic [MAG_W-1:0] v);
    logic [BYTE_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < OPERAND_BYTES; i++) begin
      if (v[i*8 +: 8] != 8'd0) n = BYTE_CNT_W'(i + 1);
    end
    return n;
  endfunction

endpackage : smwa_pkg
`default_nettype wire

>>> rtl/core/smwa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smwa_in_if / smwa_out_if
// valid/ready channels for operand items and result items
// ----------------------------------------------------------------------------
interface smwa_in_if;
  logic             valid;
  logic             ready;
  smwa_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : smwa_in_if

interface smwa_out_if;
  logic              valid;
  logic              ready;
  smwa_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : smwa_out_if
`default_nettype wire

>>> rtl/core/smwa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smwa_ctrl
// sequencer: accepts an item, runs iterations, holds result until transfer
// ----------------------------------------------------------------------------
module smwa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output smwa_pkg::dp_cmd_t         cmd,
  input  wire smwa_pkg::dp_status_t status
);
  import smwa_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (status.iterative && !status.last) begin
          cmd.step = 1'b1;
        end else begin
          if (status.iterative) cmd.step = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // one transfer in flight at most
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in_ready with out_valid");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_ITER) else $error("load did not start work");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule : smwa_ctrl
`default_nettype wire

>>> rtl/core/smwa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smwa_dp
// datapath: add/sub/compare in one step, shift-add multiply and restoring
// divide one bit per cycle
// ----------------------------------------------------------------------------
module smwa_dp (
  input  wire logic                 clk,
  input  wire smwa_pkg::in_item_t   in_data,
  input  wire smwa_pkg::dp_cmd_t    cmd,
  output smwa_pkg::dp_status_t      status,
  output smwa_pkg::out_item_t       out_data
);
  import smwa_pkg::*;

  logic [2:0]       mode_r;
  logic             an_r, bn_r;
  logic [MAG_W-1:0] am_r, bm_r;
  logic [MAG_W-1:0] acc_r;     // product or remainder
  logic [MAG_W-1:0] q_r;       // multiplier shifter or quotient
  logic [CNT_W-1:0] cnt_r;
  logic             skip_r;    // error detected at load, no iteration
  out_item_t        res_r;
  out_item_t        res_nxt;

  logic [MAG_W-1:0] am_in, bm_in;
  logic             mul_ovf;

  assign am_in   = in_data.a_magnitude[MAG_W-1:0];
  assign bm_in   = in_data.b_magnitude[MAG_W-1:0];
  assign mul_ovf = ({1'b0, sig_bytes(am_in)} + {1'b0, sig_bytes(bm_in)})
                   > (BYTE_CNT_W+1)'(OPERAND_BYTES);

  assign status.iterative = (mode_r == MODE_MUL || mode_r == MODE_DIV) && !skip_r;
  assign status.last      = cnt_r == CNT_W'(MAG_W - 1);

  // single-step ops
  logic             same_sign;
  logic [MAG_W:0]   sum;
  logic             a_ge_b;
  logic [MAG_W-1:0] diff_ab, diff_ba;
  logic             eff_bn, aneg, bneg;
  logic [1:0]       cmp;
  assign eff_bn    = (mode_r == MODE_SUB) ? !bn_r : bn_r;
  assign same_sign = an_r == eff_bn;
  assign sum       = {1'b0, am_r} + {1'b0, bm_r};
  assign a_ge_b    = am_r >= bm_r;
  assign diff_ab   = am_r - bm_r;
  assign diff_ba   = bm_r - am_r;
  assign aneg      = an_r && (am_r != '0);
  assign bneg      = bn_r && (bm_r != '0);
  always_comb begin
    if (aneg != bneg)        cmp = aneg ? CMP_LESS : CMP_GREATER;
    else if (am_r == bm_r)   cmp = CMP_EQUAL;
    else if ((am_r > bm_r) != aneg) cmp = CMP_GREATER;
    else                     cmp = CMP_LESS;
  end

  // one iteration step
  logic [MAG_W:0]   rem_sh;
  logic [MAG_W:0]   rem_sub;
  assign rem_sh  = {acc_r, q_r[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, bm_r};

  // registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      an_r   <= in_data.a_negative;
      bn_r   <= in_data.b_negative;
      am_r   <= am_in;
      bm_r   <= bm_in;
      acc_r  <= '0;
      cnt_r  <= '0;
      q_r    <= (in_data.mode == MODE_DIV) ? am_in : bm_in;
      skip_r <= (in_data.mode == MODE_MUL) ? mul_ovf
              : (in_data.mode == MODE_DIV) ? (bm_in == '0) : 1'b0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (mode_r == MODE_MUL) begin
        // msb-first shift-add, product fits by the byte check
        acc_r <= (acc_r << 1) + (q_r[MAG_W-1] ? am_r : '0);
        q_r   <= q_r << 1;
      end else begin
        if (!rem_sub[MAG_W]) begin
          acc_r <= rem_sub[MAG_W-1:0];
          q_r   <= {q_r[MAG_W-2:0], 1'b1};
        end else begin
          acc_r <= rem_sh[MAG_W-1:0];
          q_r   <= {q_r[MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  // final result, takes the stepped values on the last step
  logic [MAG_W-1:0] mul_fin, div_fin;
  assign mul_fin = (acc_r << 1) + (q_r[MAG_W-1] ? am_r : '0);
  assign div_fin = {q_r[MAG_W-2:0], !rem_sub[MAG_W]};

  always_comb begin
    res_nxt = '0;
    case (mode_r)
      MODE_ADD, MODE_SUB: begin
        if (same_sign) begin
          if (sum[MAG_W]) begin
            res_nxt.error_code = ERR_OVERFLOW;
          end else begin
            res_nxt.result_magnitude = 64'(sum[MAG_W-1:0]);
            res_nxt.result_negative  = an_r && (sum[MAG_W-1:0] != '0);
          end
        end else if (a_ge_b) begin
          res_nxt.result_magnitude = 64'(diff_ab);
          res_nxt.result_negative  = an_r && (diff_ab != '0);
        end else begin
          res_nxt.result_magnitude = 64'(diff_ba);
          res_nxt.result_negative  = eff_bn;
        end
      end
      MODE_MUL: begin
        if (skip_r) res_nxt.error_code = ERR_OVERFLOW;
        else begin
          res_nxt.result_magnitude = 64'(mul_fin);
          res_nxt.result_negative  = (an_r != bn_r) && (mul_fin != '0);
        end
      end
      MODE_DIV: begin
        if (skip_r) res_nxt.error_code = ERR_DIV_ZERO;
        else begin
          res_nxt.result_magnitude = 64'(div_fin);
          res_nxt.result_negative  = (an_r != bn_r) && (div_fin != '0);
        end
      end
      MODE_CMP: res_nxt.compare_result = cmp;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) res_r <= res_nxt;
  end

  assign out_data = res_r;

  a_zero_pos: assert property (@(posedge clk)
    $past(cmd.finish) |-> !(res_r.result_negative && res_r.result_magnitude == '0))
    else $error("negative zero result");
  a_err_zero: assert property (@(posedge clk)
    $past(cmd.finish) && res_r.error_code != ERR_OK |-> res_r.result_magnitude == '0)
    else $error("error with nonzero magnitude");
  a_cmp_only: assert property (@(posedge clk)
    $past(cmd.finish) && $past(mode_r) != MODE_CMP |-> res_r.compare_result == CMP_LESS)
    else $error("compare code outside compare mode");
endmodule : smwa_dp
`default_nettype wire

>>> rtl/core/sign_magnitude_wide_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sign_magnitude_wide_alu
// sign-magnitude add, subtract, multiply, divide and compare on 64-bit
// magnitudes
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in      | sink      | mode, a_negative, a_magnitude, b_negative, b_magnitude
//  out     | source    | result_negative, result_magnitude, compare_result,
//          |           | error_code
//
//  add, subtract, compare and error cases: the sequencer passes through
//  ITER once and the registered result is valid in DONE; multiply and
//  divide: the sequencer stays in ITER for one magnitude bit per cycle
//  through the shared shift-add / restoring-subtract datapath, then the
//  result is valid in DONE.
//  one item in flight; in_ready is low until the result is transferred.
//  rst_n is synchronous, active low, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module sign_magnitude_wide_alu (
  input  wire logic clk,
  input  wire logic rst_n,
  smwa_in_if.sink   in_ch,
  smwa_out_if.source out_ch
);
  import smwa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  smwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  smwa_dp u_dp (
    .clk      (clk),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_ch.data)
  );
endmodule : sign_magnitude_wide_alu
`default_nettype wire
